// ===== hdl/i2cmbs_pkg.sv =====
// Shared constants for the I2C master bit sequencer: field widths,
// beat kinds, register indexes and sequencer step codes. No dependencies.
package i2cmbs_pkg;

  localparam int PHASE_W   = 16;
  localparam int TMO_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int STEP_W    = 4;
  localparam int BIT_W     = 4;
  localparam int CFG_A_W   = 1;
  localparam int CFG_D_W   = 16;
  localparam int IN_D_W    = 16;
  localparam int OUT_D_W   = 16;

  // beat kinds; codes above KIND_READ behave as ticks
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_ACK_TIMEOUT = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd1;
  localparam logic [TMO_W-1:0]   ACK_TIMEOUT_RST = 8'd250;

  // sequencer steps
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_START_A  = 4'd1;
  localparam logic [STEP_W-1:0] ST_START_B  = 4'd2;
  localparam logic [STEP_W-1:0] ST_STOP_A   = 4'd3;
  localparam logic [STEP_W-1:0] ST_STOP_B   = 4'd4;
  localparam logic [STEP_W-1:0] ST_FINAL    = 4'd5;
  localparam logic [STEP_W-1:0] ST_WR_LOW   = 4'd6;
  localparam logic [STEP_W-1:0] ST_WR_HIGH  = 4'd7;
  localparam logic [STEP_W-1:0] ST_ACK_REL  = 4'd8;
  localparam logic [STEP_W-1:0] ST_ACK_HIGH = 4'd9;
  localparam logic [STEP_W-1:0] ST_ACK_WAIT = 4'd10;
  localparam logic [STEP_W-1:0] ST_RD_HIGH  = 4'd11;
  localparam logic [STEP_W-1:0] ST_RD_LOW   = 4'd12;
  localparam logic [STEP_W-1:0] ST_AK_A     = 4'd13;
  localparam logic [STEP_W-1:0] ST_AK_B     = 4'd14;
  localparam logic [STEP_W-1:0] ST_AK_C     = 4'd15;

  localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

  // result beat fields
  typedef struct packed {
    logic              rejected;
    logic              ack_error;
    logic [BYTE_W-1:0] rd_data;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl;
  } res_t;

endpackage

// ===== hdl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer top level: phase sequencer, config registers
// and output register. Depends on i2cmbs_pkg.
//
// Usage:
//   Input channel (in_*): every beat is a tick or a command (start, stop,
//   write byte, read byte) selected by in_tuser. Ticks pace the bus: each
//   SCL/SDA action is followed by phase_ticks ticks. Commands are taken
//   only when the sequencer is idle; a command that lands while busy is
//   flagged as rejected and otherwise ignored.
//   Output channel (out_*): exactly one result beat per input beat, giving
//   the SCL/SDA drive levels, busy/done, last read byte, ack error and the
//   rejected flag as they stand after that beat.
//   Config port (cfg_*): phase_ticks (index 0) and ack_timeout (index 1), for the user
//   to write only while the bus sequence is idle; the block itself does not enforce this.
// Latency/throughput: one beat per clock while the output is not stalled; the
//   result of a beat shows on out_tdata in the cycle after it is taken. The single
//   result register, fed by combinational next-state logic, sets this.
// Stall: in_tready drops only while a result is held in the output
//   register and the receiver is stalling; no beat is dropped.
// Reset: synchronous active-low rst_n returns the sequencer to idle with
//   SCL and SDA released, registers at phase_ticks=1 and ack_timeout=250.
module i2c_master_bit_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  // slave side
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cmbs_pkg::IN_D_W-1:0]     in_tdata,  // wr_data[7:0], send_ack, sda_in, zero pad
  input  logic [i2cmbs_pkg::KIND_W-1:0]     in_tuser,  // kind
  // master side
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // scl, sda_out, busy_res, done_res, rd_data[7:0], ack_error, rejected, zero pad
  output logic [i2cmbs_pkg::OUT_D_W-1:0]    out_tdata,
  // config
  input  logic                              cfg_we,
  input  logic [i2cmbs_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [i2cmbs_pkg::CFG_D_W-1:0]    cfg_wdata
);
  import i2cmbs_pkg::*;

  // config registers
  logic [PHASE_W-1:0] phase_ticks_r;
  logic [TMO_W-1:0]   ack_timeout_r;

  // sequencer state
  logic [STEP_W-1:0]  step_r,       step_nxt;
  logic [PHASE_W-1:0] phase_cnt_r,  phase_cnt_nxt;
  logic [BIT_W-1:0]   bit_idx_r,    bit_idx_nxt;
  logic [BYTE_W-1:0]  shift_r,      shift_nxt;
  logic [TMO_W-1:0]   wait_cnt_r,   wait_cnt_nxt;
  logic               ack_choice_r, ack_choice_nxt;
  logic               scl_r,        scl_nxt;
  logic               sda_r,        sda_nxt;
  logic               err_r,        err_nxt;
  logic [BYTE_W-1:0]  rd_byte_r,    rd_byte_nxt;

  // output register
  logic               out_valid_r;
  res_t               res_r, res_nxt;

  // input beat fields
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  wr_data;
  logic               send_ack;
  logic               sda_in;
  logic               in_fire;
  logic               is_cmd;
  logic               busy;

  // delay counter helpers
  logic [PHASE_W-1:0] limit;
  logic [PHASE_W:0]   pc_inc;
  logic               delay_over;
  logic [BIT_W-1:0]   bit_inc;
  logic [BYTE_W-1:0]  shift_sh;

  logic               done;
  logic               rejected;

  assign kind     = in_tuser;
  assign wr_data  = in_tdata[BYTE_W-1:0];
  assign send_ack = in_tdata[BYTE_W];
  assign sda_in   = in_tdata[BYTE_W+1];

  // one output slot: take a beat whenever it is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign is_cmd = (kind == KIND_START) || (kind == KIND_STOP) ||
                  (kind == KIND_WRITE) || (kind == KIND_READ);
  assign busy   = (step_r != ST_IDLE);

  // zero phase_ticks behaves as one
  assign limit      = (phase_ticks_r == '0) ? PHASE_W'(1) : phase_ticks_r;
  assign pc_inc     = {1'b0, phase_cnt_r} + (PHASE_W+1)'(1);
  assign delay_over = (pc_inc >= {1'b0, limit});
  assign bit_inc    = bit_idx_r + BIT_W'(1);
  assign shift_sh   = {shift_r[BYTE_W-2:0], 1'b0};

  always_comb begin
    step_nxt       = step_r;
    phase_cnt_nxt  = phase_cnt_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    wait_cnt_nxt   = wait_cnt_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    err_nxt        = err_r;
    rd_byte_nxt    = rd_byte_r;
    done           = 1'b0;
    rejected       = 1'b0;

    if (is_cmd && busy) begin
      rejected = 1'b1;
    end else if (is_cmd) begin
      // first bus action happens on the command beat itself
      bit_idx_nxt   = '0;
      phase_cnt_nxt = '0;
      priority case (kind)
        KIND_START: begin
          sda_nxt  = 1'b1;
          scl_nxt  = 1'b1;
          step_nxt = ST_START_A;
        end
        KIND_STOP: begin
          sda_nxt  = 1'b0;
          step_nxt = ST_STOP_A;
        end
        KIND_WRITE: begin
          err_nxt   = 1'b0;
          shift_nxt = wr_data;
          sda_nxt   = wr_data[BYTE_W-1];
          step_nxt  = ST_WR_LOW;
        end
        default: begin
          ack_choice_nxt = send_ack;
          shift_nxt      = '0;
          sda_nxt        = 1'b1;
          scl_nxt        = 1'b1;
          step_nxt       = ST_RD_HIGH;
        end
      endcase
    end else if (step_r == ST_ACK_WAIT) begin
      // ack poll: one SDA sample per tick, no phase delay
      if (!sda_in) begin
        scl_nxt       = 1'b0;
        step_nxt      = ST_FINAL;
        phase_cnt_nxt = '0;
      end else if (wait_cnt_r >= ack_timeout_r) begin
        err_nxt       = 1'b1;
        sda_nxt       = 1'b0;
        step_nxt      = ST_STOP_A;
        phase_cnt_nxt = '0;
      end else begin
        wait_cnt_nxt = wait_cnt_r + TMO_W'(1);
      end
    end else if (busy) begin
      if (!delay_over) begin
        phase_cnt_nxt = pc_inc[PHASE_W-1:0];
      end else begin
        phase_cnt_nxt = '0;
        unique case (step_r)
          ST_START_A: begin
            sda_nxt  = 1'b0;
            step_nxt = ST_START_B;
          end
          ST_START_B: begin
            scl_nxt  = 1'b0;
            step_nxt = ST_FINAL;
          end
          ST_STOP_A: begin
            scl_nxt  = 1'b1;
            step_nxt = ST_STOP_B;
          end
          ST_STOP_B: begin
            sda_nxt  = 1'b1;
            step_nxt = ST_FINAL;
          end
          ST_FINAL: begin
            step_nxt = ST_IDLE;
            done     = 1'b1;
          end
          ST_WR_LOW: begin
            scl_nxt  = 1'b1;
            step_nxt = ST_WR_HIGH;
          end
          ST_WR_HIGH: begin
            scl_nxt     = 1'b0;
            bit_idx_nxt = bit_inc;
            shift_nxt   = shift_sh;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_nxt  = shift_sh[BYTE_W-1];
              step_nxt = ST_WR_LOW;
            end else begin
              sda_nxt  = 1'b1;   // release for slave ack
              step_nxt = ST_ACK_REL;
            end
          end
          ST_ACK_REL: begin
            scl_nxt  = 1'b1;
            step_nxt = ST_ACK_HIGH;
          end
          ST_ACK_HIGH: begin
            wait_cnt_nxt = '0;
            step_nxt     = ST_ACK_WAIT;
          end
          ST_RD_HIGH: begin
            shift_nxt = {shift_r[BYTE_W-2:0], sda_in};
            scl_nxt   = 1'b0;
            step_nxt  = ST_RD_LOW;
          end
          ST_RD_LOW: begin
            bit_idx_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              scl_nxt  = 1'b1;
              step_nxt = ST_RD_HIGH;
            end else begin
              rd_byte_nxt = shift_r;
              sda_nxt     = !ack_choice_r;
              step_nxt    = ST_AK_A;
            end
          end
          ST_AK_A: begin
            scl_nxt  = 1'b1;
            step_nxt = ST_AK_B;
          end
          ST_AK_B: begin
            scl_nxt  = 1'b0;
            step_nxt = ST_AK_C;
          end
          ST_AK_C: begin
            if (ack_choice_r) begin
              sda_nxt  = 1'b1;
              step_nxt = ST_FINAL;
            end else begin
              step_nxt = ST_IDLE;
              done     = 1'b1;
            end
          end
          default: begin
            step_nxt = ST_IDLE;
          end
        endcase
      end
    end

    res_nxt.scl       = scl_nxt;
    res_nxt.sda_out   = sda_nxt;
    res_nxt.busy_res  = (step_nxt != ST_IDLE);
    res_nxt.done_res  = done;
    res_nxt.rd_data   = rd_byte_nxt;
    res_nxt.ack_error = err_nxt;
    res_nxt.rejected  = rejected;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PHASE_TICKS: phase_ticks_r <= cfg_wdata[PHASE_W-1:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_IDLE;
      phase_cnt_r  <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      wait_cnt_r   <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      err_r        <= 1'b0;
      rd_byte_r    <= '0;
    end else if (in_fire) begin
      step_r       <= step_nxt;
      phase_cnt_r  <= phase_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      err_r        <= err_nxt;
      rd_byte_r    <= rd_byte_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_D_W - $bits(res_t))'(0), res_r};

`ifndef ASSERT_OFF
  // busy flag in the result beat tracks the sequencer step
  a_busy_tracks_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (res_r.busy_res == (step_r != ST_IDLE)))
    else $error("busy_res disagrees with sequencer step");

  // a rejected command leaves the sequence untouched
  a_reject_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_cmd && busy) |=> (res_r.rejected && step_r == $past(step_r)
                                     && phase_cnt_r == $past(phase_cnt_r)))
    else $error("rejected command disturbed the sequence");

  // completion always lands in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && done) |=> (step_r == ST_IDLE && !res_r.busy_res))
    else $error("done raised while sequence still running");

  // state only moves on an accepted beat
  a_step_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(step_r) && $stable(phase_cnt_r))
    else $error("sequencer state moved without an input beat");
`endif

endmodule
